// ----- hdl/ctt_pkg.sv -----
// Package for the Content-Type tokenizer: character codes, record kinds,
// parse phase codes and helper functions. No dependencies.
package ctt_pkg;

  localparam int unsigned MaxStringBytesDefault = 4096;

  // Width of every length and offset field on the result channel.
  localparam int unsigned LenW = 13;

  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChEqual = 8'h3D;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam logic [1:0] KindType  = 2'd0;
  localparam logic [1:0] KindPair  = 2'd1;
  localparam logic [1:0] KindDone  = 2'd2;
  localparam logic [1:0] KindError = 2'd3;

  localparam logic [1:0] PhaseType  = 2'd0;
  localparam logic [1:0] PhaseKey   = 2'd1;
  localparam logic [1:0] PhaseValue = 2'd2;

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == ChSpace) || (ch == ChTab) || (ch == ChCr);
  endfunction

  function automatic logic is_term(input logic [7:0] ch);
    return (ch == ChSemi) || (ch == ChSpace) || (ch == ChTab);
  endfunction

endpackage

// ----- hdl/content_type_tokenizer.sv -----
// Content-Type tokenizer: one input register, the parse step, one result register.
// Depends on ctt_pkg for character codes, record kinds and phase codes.
//
// An accepted item passes from the input register through the parse step into the result register.
// One item per cycle while the output is not stalled; the parse state updates in a single step per byte.
// An item causes at most one result; bytes inside a string that finish nothing give none.
// Reset (rst_ni low, asynchronous) empties both registers and clears the parse state.
module content_type_tokenizer #(
  parameter int unsigned MAX_STRING_BYTES = ctt_pkg::MaxStringBytesDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                char_byte_i,
  input  logic                      end_of_string_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                record_kind_o,
  output logic [ctt_pkg::LenW-1:0]  type_length_o,
  output logic [ctt_pkg::LenW-1:0]  key_start_o,
  output logic [ctt_pkg::LenW-1:0]  key_length_o,
  output logic [ctt_pkg::LenW-1:0]  value_start_o,
  output logic [ctt_pkg::LenW-1:0]  value_length_o,
  output logic                      final_record_o
);

  // Offsets reach MAX_STRING_BYTES + 1 at most.
  localparam int unsigned PosW = $clog2(MAX_STRING_BYTES + 2);
  localparam int unsigned LenW = ctt_pkg::LenW;
  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_STRING_BYTES);
  localparam logic [PosW-1:0] PosOne = PosW'(1);

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_char_q;
  logic       s1_eos_q;

  // Parse state.
  logic [1:0]      phase_q, phase_d;
  logic            in_quote_q, in_quote_d;
  logic [PosW-1:0] run_q, run_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] kbeg_q, kbeg_d;
  logic [PosW-1:0] klen_q, klen_d;
  logic [PosW-1:0] vbeg_q, vbeg_d;
  logic            skip_q, skip_d;
  logic            qpend_q, qpend_d;
  logic            failed_q, failed_d;

  // Result register.
  logic            out_valid_q, out_valid_d;
  logic [1:0]      kind_q, kind_d;
  logic [PosW-1:0] tlen_q, tlen_d;
  logic [PosW-1:0] ks_q, ks_d;
  logic [PosW-1:0] kl_q, kl_d;
  logic [PosW-1:0] vs_q, vs_d;
  logic [PosW-1:0] vl_q, vl_d;
  logic            final_q, final_d;
  logic            rec_valid;

  logic out_free, s1_fire, in_fire, byte_go;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_fire);

  always_comb begin
    phase_d    = phase_q;
    in_quote_d = in_quote_q;
    run_d      = run_q;
    pos_d      = pos_q;
    kbeg_d     = kbeg_q;
    klen_d     = klen_q;
    vbeg_d     = vbeg_q;
    skip_d     = skip_q;
    qpend_d    = qpend_q;
    failed_d   = failed_q;
    rec_valid  = 1'b0;
    kind_d     = ctt_pkg::KindDone;
    tlen_d     = '0;
    ks_d       = '0;
    kl_d       = '0;
    vs_d       = '0;
    vl_d       = '0;
    final_d    = 1'b0;
    byte_go    = 1'b1;

    if (failed_q) begin
      // Rest of a failed string is swallowed.
    end else if (pos_q >= PosLimit) begin
      failed_d  = 1'b1;
      rec_valid = 1'b1;
      kind_d    = ctt_pkg::KindError;
      final_d   = 1'b1;
    end else begin
      // Resolve a quote seen on the previous byte now that its successor is known.
      if (qpend_q) begin
        qpend_d = 1'b0;
        if (ctt_pkg::is_term(s1_char_q) && in_quote_q) begin
          vbeg_d     = vbeg_q + PosOne;
          in_quote_d = 1'b0;
        end else begin
          run_d = run_q + PosOne;
        end
      end

      if (skip_q) begin
        if (ctt_pkg::is_blank(s1_char_q)) begin
          byte_go = 1'b0;
          if (phase_q == ctt_pkg::PhaseKey) begin
            kbeg_d = pos_q + PosOne;
          end else begin
            vbeg_d = pos_q + PosOne;
          end
        end else begin
          skip_d = 1'b0;
        end
      end

      if (byte_go) begin
        unique case (phase_q)
          ctt_pkg::PhaseType: begin
            if (ctt_pkg::is_term(s1_char_q)) begin
              rec_valid = 1'b1;
              kind_d    = ctt_pkg::KindType;
              tlen_d    = run_d;
              run_d     = '0;
              phase_d   = ctt_pkg::PhaseKey;
              skip_d    = 1'b1;
              kbeg_d    = pos_q + PosOne;
            end else begin
              run_d = run_d + PosOne;
            end
          end
          ctt_pkg::PhaseKey: begin
            if (s1_char_q == ctt_pkg::ChEqual) begin
              klen_d  = run_d;
              run_d   = '0;
              phase_d = ctt_pkg::PhaseValue;
              skip_d  = 1'b1;
              vbeg_d  = pos_q + PosOne;
            end else if (!ctt_pkg::is_blank(s1_char_q)) begin
              run_d = run_d + PosOne;
            end else if (run_d != '0) begin
              failed_d  = 1'b1;
              rec_valid = 1'b1;
              kind_d    = ctt_pkg::KindError;
              final_d   = 1'b1;
            end
          end
          default: begin
            if (ctt_pkg::is_term(s1_char_q) && !in_quote_d) begin
              rec_valid = 1'b1;
              kind_d    = ctt_pkg::KindPair;
              ks_d      = kbeg_d;
              kl_d      = klen_d;
              vs_d      = vbeg_d;
              vl_d      = run_d;
              run_d     = '0;
              klen_d    = '0;
              phase_d   = ctt_pkg::PhaseKey;
              skip_d    = 1'b1;
              kbeg_d    = pos_q + PosOne;
            end else if (s1_char_q == ctt_pkg::ChQuote) begin
              if (run_d == '0) begin
                in_quote_d = 1'b1;
              end else if (s1_eos_q) begin
                // No byte follows, so the end of the string decides the quote.
                if (in_quote_d) begin
                  vbeg_d     = vbeg_d + PosOne;
                  in_quote_d = 1'b0;
                end else begin
                  run_d = run_d + PosOne;
                end
              end else begin
                qpend_d = 1'b1;
              end
            end else begin
              run_d = run_d + PosOne;
            end
          end
        endcase
      end

      pos_d = pos_q + PosOne;

      // The end of the string closes an open media type or value like a ';'.
      if (!failed_d && s1_eos_q && !(phase_d == ctt_pkg::PhaseKey && skip_d)) begin
        if (phase_d == ctt_pkg::PhaseType) begin
          rec_valid = 1'b1;
          kind_d    = ctt_pkg::KindType;
          tlen_d    = run_d;
        end else if (phase_d == ctt_pkg::PhaseValue && !in_quote_d) begin
          rec_valid = 1'b1;
          kind_d    = ctt_pkg::KindPair;
          ks_d      = kbeg_d;
          kl_d      = klen_d;
          vs_d      = vbeg_d;
          vl_d      = run_d;
        end
      end

      if (!failed_d && s1_eos_q) begin
        rec_valid = 1'b1;
        final_d   = 1'b1;
      end
    end

    if (s1_eos_q) begin
      phase_d    = ctt_pkg::PhaseType;
      in_quote_d = 1'b0;
      run_d      = '0;
      pos_d      = '0;
      kbeg_d     = '0;
      klen_d     = '0;
      vbeg_d     = '0;
      skip_d     = 1'b0;
      qpend_d    = 1'b0;
      failed_d   = 1'b0;
    end
  end

  always_comb begin
    if (out_free) begin
      out_valid_d = s1_fire && rec_valid;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= ctt_pkg::PhaseType;
      in_quote_q  <= 1'b0;
      run_q       <= '0;
      pos_q       <= '0;
      kbeg_q      <= '0;
      klen_q      <= '0;
      vbeg_q      <= '0;
      skip_q      <= 1'b0;
      qpend_q     <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        phase_q    <= phase_d;
        in_quote_q <= in_quote_d;
        run_q      <= run_d;
        pos_q      <= pos_d;
        kbeg_q     <= kbeg_d;
        klen_q     <= klen_d;
        vbeg_q     <= vbeg_d;
        skip_q     <= skip_d;
        qpend_q    <= qpend_d;
        failed_q   <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_char_q <= char_byte_i;
      s1_eos_q  <= end_of_string_i;
    end
    if (s1_fire && out_free) begin
      kind_q  <= kind_d;
      tlen_q  <= tlen_d;
      ks_q    <= ks_d;
      kl_q    <= kl_d;
      vs_q    <= vs_d;
      vl_q    <= vl_d;
      final_q <= final_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign record_kind_o  = kind_q;
  assign type_length_o  = LenW'(tlen_q);
  assign key_start_o    = LenW'(ks_q);
  assign key_length_o   = LenW'(kl_q);
  assign value_start_o  = LenW'(vs_q);
  assign value_length_o = LenW'(vl_q);
  assign final_record_o = final_q;

  // An error or done record always closes its string.
  a_error_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (record_kind_o == ctt_pkg::KindError || record_kind_o == ctt_pkg::KindDone)
    |-> final_record_o)
    else $error("error or done record without final flag");

  // A pending quote decision only exists while a value is being read.
  a_qpend_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpend_q |-> (phase_q == ctt_pkg::PhaseValue))
    else $error("pending quote outside value phase");

  // The last byte of a string returns the parser to its start.
  a_eos_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_eos_q |=> (pos_q == '0) && (phase_q == ctt_pkg::PhaseType) && !failed_q)
    else $error("state not cleared after end of string");

  // The byte position never runs past the string limit.
  a_pos_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosLimit)
    else $error("position beyond string limit");

  // A failed string produces no further records until it ends.
  a_failed_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && failed_q |=> !out_valid_o)
    else $error("record produced after failure");

endmodule
